/* src/rqnt_pkg.sv */
// ----------------------------------------------------------------------------
// rqnt_pkg: shared types and constants for the read quality and N trimmer
// Field widths, register indexes, verdict codes and the per-read result type.
// ----------------------------------------------------------------------------
package rqnt_pkg;

    localparam int MAX_READ_LEN = 1024;
    localparam int CNT_W        = $clog2(MAX_READ_LEN + 1);

    localparam int CHAR_W   = 8;
    localparam int THRESH_W = 8;
    localparam int OFFSET_W = 8;
    localparam int CFG_W    = CNT_W;
    localparam int CFG_AW   = 3;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_AW-1:0] REG_QUALITY_OFFSET  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_N_LIMIT         = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MINIMUM_LENGTH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PAIRED_MODE     = 3'd4;

    // reset values
    localparam logic [THRESH_W-1:0] RST_SCORE_THRESHOLD = 8'd0;
    localparam logic [OFFSET_W-1:0] RST_QUALITY_OFFSET  = 8'd33;
    localparam logic [CNT_W-1:0]    RST_N_LIMIT         = 11'd0;
    localparam logic [CNT_W-1:0]    RST_MINIMUM_LENGTH  = 11'd23;

    // unknown base letters
    localparam logic [CHAR_W-1:0] CHAR_N_UPPER = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_N_LOWER = 8'h6E;

    // verdict codes
    localparam int VERDICT_W = 2;
    localparam logic [VERDICT_W-1:0] VERDICT_DISCARD     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_KEEP        = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FIRST_ONLY  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_SECOND_ONLY = 2'd3;

    // trim coordinates of one read; start sits in the low bits
    typedef struct packed {
        logic [CNT_W-1:0] n_count;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] end_trim;
        logic [CNT_W-1:0] start;
    } read_result_t;

    localparam int RESULT_W = $bits(read_result_t);

    function automatic logic read_ok(input read_result_t r,
                                     input logic [CNT_W-1:0] n_limit,
                                     input logic [CNT_W-1:0] min_len);
        return (r.n_count <= n_limit) && (r.length > min_len);
    endfunction

endpackage

/* src/read_quality_and_n_trimmer.sv */
// ----------------------------------------------------------------------------
// read_quality_and_n_trimmer: quality and N end trimming of sequencing reads
// Result path: the final base of a read passes the input register, then the
//   result register, which drives m_tvalid.
// Throughput: one base per cycle; the only stall is a base that closes a
//   single read or second mate and meets a full, untaken result register.
// Reset: async active low; clears trim state, held first mate and registers.
// ----------------------------------------------------------------------------
module read_quality_and_n_trimmer
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [rqnt_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [rqnt_pkg::CFG_W-1:0]       cfg_data,
    // base stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [7:0] base, [15:8] quality
    input  logic                             s_tuser,   // [0] mate
    input  logic                             s_tlast,   // final base of the read
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [2*rqnt_pkg::RESULT_W-1:0]  m_tdata,   // first_start, first_end_trim,
                                                        // first_length, first_n_count,
                                                        // second_start, second_end_trim,
                                                        // second_length, second_n_count
    output logic [rqnt_pkg::VERDICT_W-1:0]   m_tuser    // [1:0] verdict
);
    import rqnt_pkg::*;

    // ---------------- configuration registers ----------------
    logic [THRESH_W-1:0] score_threshold_reg;
    logic [OFFSET_W-1:0] quality_offset_reg;
    logic [CNT_W-1:0]    n_limit_reg;
    logic [CNT_W-1:0]    minimum_length_reg;
    logic                paired_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= RST_SCORE_THRESHOLD;
            quality_offset_reg  <= RST_QUALITY_OFFSET;
            n_limit_reg         <= RST_N_LIMIT;
            minimum_length_reg  <= RST_MINIMUM_LENGTH;
            paired_mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_QUALITY_OFFSET:  quality_offset_reg  <= cfg_data[OFFSET_W-1:0];
                REG_N_LIMIT:         n_limit_reg         <= cfg_data[CNT_W-1:0];
                REG_MINIMUM_LENGTH:  minimum_length_reg  <= cfg_data[CNT_W-1:0];
                REG_PAIRED_MODE:     paired_mode_reg     <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ---------------- input register ----------------
    // One base waits here; it is processed (trim state updated) in the cycle
    // it leaves this register.
    logic                s1_valid_reg;
    logic [CHAR_W-1:0]   s1_base_reg;
    logic [CHAR_W-1:0]   s1_qual_reg;
    logic                s1_mate_reg;
    logic                s1_last_reg;

    logic s_fire;
    logic s1_fire;
    logic s1_emits;     // this base closes a single read or a second mate
    logic out_free;     // result register can take a new result this cycle

    logic                  out_valid_reg;
    logic [VERDICT_W-1:0]  out_verdict_reg;
    read_result_t          out_first_reg;
    read_result_t          out_second_reg;

    assign s1_emits = s1_last_reg && (!paired_mode_reg || s1_mate_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_emits || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_base_reg <= s_tdata[CHAR_W-1:0];
            s1_qual_reg <= s_tdata[2*CHAR_W-1:CHAR_W];
            s1_mate_reg <= s_tuser;
            s1_last_reg <= s_tlast;
        end
    end

    // ---------------- trim state ----------------
    read_result_t rd;

    rqnt_read_tracker u_tracker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (s1_fire),
        .base            (s1_base_reg),
        .quality         (s1_qual_reg),
        .last            (s1_last_reg),
        .score_threshold (score_threshold_reg),
        .quality_offset  (quality_offset_reg),
        .result          (rd)
    );

    // ---------------- mate pairing and verdict ----------------
    // The first mate is held until its second mate ends; an all-zero held
    // value stands for "no first mate" (length 0, never kept).
    read_result_t first_reg;
    logic         ok_first;
    logic         ok_read;

    logic [VERDICT_W-1:0] verdict_next;
    read_result_t         first_out_next;
    read_result_t         second_out_next;

    assign ok_first = read_ok(first_reg, n_limit_reg, minimum_length_reg);
    assign ok_read  = read_ok(rd, n_limit_reg, minimum_length_reg);

    always_comb
    begin
        if (!paired_mode_reg)
        begin
            verdict_next    = ok_read ? VERDICT_KEEP : VERDICT_DISCARD;
            first_out_next  = rd;
            second_out_next = '0;
        end
        else
        begin
            first_out_next  = first_reg;
            second_out_next = rd;
            if (ok_first && ok_read)
                verdict_next = VERDICT_KEEP;
            else if (ok_first)
                verdict_next = VERDICT_FIRST_ONLY;
            else if (ok_read)
                verdict_next = VERDICT_SECOND_ONLY;
            else
                verdict_next = VERDICT_DISCARD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_reg <= '0;
        else if (s1_fire && s1_last_reg && paired_mode_reg)
            first_reg <= s1_mate_reg ? read_result_t'('0) : rd;
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_emits)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emits)
        begin
            out_verdict_reg <= verdict_next;
            out_first_reg   <= first_out_next;
            out_second_reg  <= second_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_verdict_reg;
    assign m_tdata  = {out_second_reg, out_first_reg};

    // ---------------- assertions ----------------
    // Trim coordinates of a result always add up to at most the read limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, out_first_reg.start} + {1'b0, out_first_reg.end_trim}
                      + {1'b0, out_first_reg.length}) <= (CNT_W + 1)'(MAX_READ_LEN))
        else $error("first read coordinates exceed read limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, out_second_reg.start} + {1'b0, out_second_reg.end_trim}
                      + {1'b0, out_second_reg.length}) <= (CNT_W + 1)'(MAX_READ_LEN))
        else $error("second read coordinates exceed read limit");

    // Single-end results carry no second mate and no one-mate verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !paired_mode_reg) |-> (out_second_reg == '0) &&
            (out_verdict_reg == VERDICT_DISCARD || out_verdict_reg == VERDICT_KEEP))
        else $error("single-end result with second mate data");

    // A stalled read-ending base never lets a new base in behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emits && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while result path is blocked");

endmodule

/* src/rqnt_read_tracker.sv */
// ----------------------------------------------------------------------------
// rqnt_read_tracker: per-read trim state
// Updates the running trim registers for one base a cycle while take is high
// and gives the read's finished coordinates as seen after the current base.
// ----------------------------------------------------------------------------
module rqnt_read_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [rqnt_pkg::CHAR_W-1:0]   base,
    input  logic [rqnt_pkg::CHAR_W-1:0]   quality,
    input  logic                          last,
    input  logic [rqnt_pkg::THRESH_W-1:0] score_threshold,
    input  logic [rqnt_pkg::OFFSET_W-1:0] quality_offset,
    output rqnt_pkg::read_result_t        result
);
    import rqnt_pkg::*;

    logic [CNT_W-1:0] position_reg,       position_next;
    logic             seen_good_reg,      seen_good_next;
    logic             seen_clean_reg,     seen_clean_next;
    logic [CNT_W-1:0] start_reg,          start_next;
    logic [CNT_W-1:0] last_clean_reg,     last_clean_next;
    logic [CNT_W-1:0] end_index_reg,      end_index_next;
    logic             end_valid_reg,      end_valid_next;
    logic [CNT_W-1:0] run_n_reg,          run_n_next;
    logic [CNT_W-1:0] n_at_clean_reg,     n_at_clean_next;
    logic [CNT_W-1:0] n_at_end_reg,       n_at_end_next;

    logic             active;
    logic             good;
    logic             is_n;
    logic [CNT_W-1:0] tail;

    // score >= threshold  <=>  quality >= offset + threshold
    assign good   = {2'b00, quality} >= ({2'b00, quality_offset} + {2'b00, score_threshold});
    assign is_n   = (base == CHAR_N_UPPER) || (base == CHAR_N_LOWER);
    assign active = position_reg < CNT_W'(MAX_READ_LEN);

    always_comb
    begin
        position_next   = position_reg;
        seen_good_next  = seen_good_reg;
        seen_clean_next = seen_clean_reg;
        start_next      = start_reg;
        last_clean_next = last_clean_reg;
        end_index_next  = end_index_reg;
        end_valid_next  = end_valid_reg;
        run_n_next      = run_n_reg;
        n_at_clean_next = n_at_clean_reg;
        n_at_end_next   = n_at_end_reg;
        if (active)
        begin
            if (good)
                seen_good_next = 1'b1;
            if (seen_good_next)
            begin
                if (!is_n)
                begin
                    if (!seen_clean_reg)
                    begin
                        seen_clean_next = 1'b1;
                        start_next      = position_reg;
                    end
                    last_clean_next = position_reg;
                    n_at_clean_next = run_n_reg;
                end
                else if (seen_clean_reg)
                begin
                    run_n_next = run_n_reg + 1'b1;
                end
            end
            if (good)
            begin
                if (seen_clean_next)
                begin
                    end_valid_next = 1'b1;
                    end_index_next = last_clean_next;
                    n_at_end_next  = n_at_clean_next;
                end
                else
                begin
                    end_index_next = position_reg;
                end
            end
            position_next = position_reg + 1'b1;
        end
    end

    // finished coordinates from the post-update state
    assign tail = position_next - end_index_next - 1'b1;

    always_comb
    begin
        if (!seen_good_next)
        begin
            result.start    = position_next;
            result.end_trim = '0;
            result.length   = '0;
            result.n_count  = '0;
        end
        else if (!end_valid_next)
        begin
            result.start    = end_index_next + 1'b1;
            result.end_trim = tail;
            result.length   = '0;
            result.n_count  = '0;
        end
        else
        begin
            result.start    = start_next;
            result.end_trim = tail;
            result.length   = end_index_next - start_next + 1'b1;
            result.n_count  = n_at_end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            seen_good_reg  <= 1'b0;
            seen_clean_reg <= 1'b0;
            start_reg      <= '0;
            last_clean_reg <= '0;
            end_index_reg  <= '0;
            end_valid_reg  <= 1'b0;
            run_n_reg      <= '0;
            n_at_clean_reg <= '0;
            n_at_end_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                position_reg   <= '0;
                seen_good_reg  <= 1'b0;
                seen_clean_reg <= 1'b0;
                start_reg      <= '0;
                last_clean_reg <= '0;
                end_index_reg  <= '0;
                end_valid_reg  <= 1'b0;
                run_n_reg      <= '0;
                n_at_clean_reg <= '0;
                n_at_end_reg   <= '0;
            end
            else
            begin
                position_reg   <= position_next;
                seen_good_reg  <= seen_good_next;
                seen_clean_reg <= seen_clean_next;
                start_reg      <= start_next;
                last_clean_reg <= last_clean_next;
                end_index_reg  <= end_index_next;
                end_valid_reg  <= end_valid_next;
                run_n_reg      <= run_n_next;
                n_at_clean_reg <= n_at_clean_next;
                n_at_end_reg   <= n_at_end_next;
            end
        end
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for read_quality_and_n_trimmer
// Streams reads base by base under changing trim settings, predicts each
// trim report in-bench and compares every report field by field, with random
// stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import rqnt_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;         // margin after the DUT result register
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_BASES   = 30;
    localparam int TAIL_BASES    = 200;
    localparam int HOLD_OFF      = 300;
    localparam int REPORT_LIMIT  = 10;

    // unused register index: a write there must change nothing
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd5;

    localparam logic [31:0] NUCLEOTIDES = "ACGT";

    // one expected report: verdict plus both sets of trim coordinates
    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        read_result_t         second;
        read_result_t         first;
    } trim_report_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_AW-1:0]          cfg_addr;
    logic [CFG_W-1:0]           cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [15:0]                s_tdata;    // [7:0] base, [15:8] quality
    logic                       s_tuser;    // [0] mate
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [2*RESULT_W-1:0]      m_tdata;    // first start, end trim, length, N count,
                                            // then the same four for the second mate
    logic [VERDICT_W-1:0]       m_tuser;    // [1:0] verdict

    read_quality_and_n_trimmer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    trim_report_t pending_reports[$];
    int           mismatch_count = 0;
    int           bases_sent     = 0;
    bit           src_idle_on    = 1'b0;
    bit           sink_idle_on   = 1'b0;
    int           hold_cycles    = 0;     // long output hold-off, counted by the sink
    int           stall_left     = 0;

    // trim settings as the block should hold them
    logic [THRESH_W-1:0] cur_threshold;
    logic [OFFSET_W-1:0] cur_offset;
    logic [CNT_W-1:0]    cur_n_limit;
    logic [CNT_W-1:0]    cur_min_len;
    logic                cur_paired;

    // per-read trim tracking
    logic [CNT_W-1:0]    trk_pos;
    logic                trk_good;        // a good-quality base was seen
    logic                trk_clean;       // a non-N base was seen after that
    logic [CNT_W-1:0]    trk_start_idx;
    logic [CNT_W-1:0]    trk_clean_idx;   // latest non-N position
    logic [CNT_W-1:0]    trk_end_idx;
    logic                trk_end_ok;
    logic [CNT_W-1:0]    trk_n_run;
    logic [CNT_W-1:0]    trk_n_at_clean;
    logic [CNT_W-1:0]    trk_n_at_end;

    // first mate waiting for its partner
    read_result_t        held_first;
    logic                held_valid;

    // ------------------------------------------------------------------
    // Trim prediction
    // ------------------------------------------------------------------
    task automatic trim_clear();
        trk_pos        = '0;
        trk_good       = 1'b0;
        trk_clean      = 1'b0;
        trk_start_idx  = '0;
        trk_clean_idx  = '0;
        trk_end_idx    = '0;
        trk_end_ok     = 1'b0;
        trk_n_run      = '0;
        trk_n_at_clean = '0;
        trk_n_at_end   = '0;
    endtask

    task automatic trim_track_base(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q);
        int   score;
        logic good;
        logic is_n;
        // signed score: quality below the offset goes negative
        score = int'(q) - int'(cur_offset);
        good  = score >= int'(cur_threshold);
        is_n  = (b == CHAR_N_UPPER) || (b == CHAR_N_LOWER);
        if (trk_pos >= MAX_READ_LEN)
            return;                           // overlong read: base ignored
        if (good)
            trk_good = 1'b1;
        if (trk_good)
        begin
            if (!is_n)
            begin
                if (!trk_clean)
                begin
                    trk_clean     = 1'b1;
                    trk_start_idx = trk_pos;
                end
                trk_clean_idx  = trk_pos;
                trk_n_at_clean = trk_n_run;
            end
            else if (trk_clean)
            begin
                trk_n_run = trk_n_run + 1'b1;
            end
        end
        if (good)
        begin
            if (trk_clean)
            begin
                trk_end_ok   = 1'b1;
                trk_end_idx  = trk_clean_idx;
                trk_n_at_end = trk_n_at_clean;
            end
            else
            begin
                trk_end_idx = trk_pos;
            end
        end
        trk_pos = trk_pos + 1'b1;
    endtask

    function automatic read_result_t trim_close_read();
        read_result_t r;
        r = '0;
        if (!trk_good)
        begin
            r.start = trk_pos;                // nothing good: whole read cut
        end
        else if (!trk_end_ok)
        begin
            // only Ns inside the good span
            r.start    = trk_end_idx + 1'b1;
            r.end_trim = trk_pos - trk_end_idx - 1'b1;
        end
        else
        begin
            r.start    = trk_start_idx;
            r.end_trim = trk_pos - trk_end_idx - 1'b1;
            r.length   = trk_end_idx - trk_start_idx + 1'b1;
            r.n_count  = trk_n_at_end;
        end
        return r;
    endfunction

    function automatic logic read_passes(input read_result_t r);
        return (r.n_count <= cur_n_limit) && (r.length > cur_min_len);
    endfunction

    task automatic predict_transfer(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q,
                                    input logic m, input logic l);
        read_result_t cur;
        read_result_t prev;
        trim_report_t rep;
        logic         ok_first;
        logic         ok_second;
        trim_track_base(b, q);
        if (!l)
            return;
        cur = trim_close_read();
        trim_clear();
        rep = '0;
        if (!cur_paired)
        begin
            rep.verdict = read_passes(cur) ? VERDICT_KEEP : VERDICT_DISCARD;
            rep.first   = cur;
            pending_reports.push_back(rep);
            return;
        end
        if (!m)
        begin
            // a later first mate replaces the held one
            held_first = cur;
            held_valid = 1'b1;
            return;
        end
        // orphan second mate pairs with an all-zero first
        prev       = held_valid ? held_first : '0;
        held_first = '0;
        held_valid = 1'b0;
        ok_first   = read_passes(prev);
        ok_second  = read_passes(cur);
        if (ok_first && ok_second)
            rep.verdict = VERDICT_KEEP;
        else if (ok_first)
            rep.verdict = VERDICT_FIRST_ONLY;
        else if (ok_second)
            rep.verdict = VERDICT_SECOND_ONLY;
        else
            rep.verdict = VERDICT_DISCARD;
        rep.first  = prev;
        rep.second = cur;
        pending_reports.push_back(rep);
    endtask

    // ------------------------------------------------------------------
    // Report checking at the rising edge
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        trim_report_t want;
        read_result_t got_first;
        read_result_t got_second;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_first  = read_result_t'(m_tdata[RESULT_W-1:0]);
            got_second = read_result_t'(m_tdata[2*RESULT_W-1:RESULT_W]);
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: report with none expected, verdict %0d", $time, m_tuser);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("verdict",         want.verdict,         m_tuser);
                check_field("first_start",     want.first.start,     got_first.start);
                check_field("first_end_trim",  want.first.end_trim,  got_first.end_trim);
                check_field("first_length",    want.first.length,    got_first.length);
                check_field("first_n_count",   want.first.n_count,   got_first.n_count);
                check_field("second_start",    want.second.start,    got_second.start);
                check_field("second_end_trim", want.second.end_trim, got_second.end_trim);
                check_field("second_length",   want.second.length,   got_second.length);
                check_field("second_n_count",  want.second.n_count,  got_second.n_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Report sink: random stall bursts and the long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Base stream driver
    // ------------------------------------------------------------------
    // Entered and left at a falling edge; tvalid stays up for a back-to-back
    // transfer and is dropped by the next call or by wait_drain.
    task automatic send_base(input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] q,
                             input logic m, input logic l);
        int gap;
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap      = $urandom_range(1, 10);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {q, b};
        s_tuser  = m;
        s_tlast  = l;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_transfer(b, q, m, l);
        bases_sent++;
        @(negedge clk);
    endtask

    // stop sending, let every report come out, then cover the pipeline
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (addr)
            REG_SCORE_THRESHOLD: cur_threshold = data[THRESH_W-1:0];
            REG_QUALITY_OFFSET:  cur_offset    = data[OFFSET_W-1:0];
            REG_N_LIMIT:         cur_n_limit   = data;
            REG_MINIMUM_LENGTH:  cur_min_len   = data;
            REG_PAIRED_MODE:     cur_paired    = data[0];
            default: ;
        endcase
    endtask

    // narrow registers get junk in their unused upper bits
    task automatic set_config(input int thr, input int offs, input int nlim, input int minlen,
                              input int paired);
        cfg_write(REG_SCORE_THRESHOLD, CFG_W'(thr) | (CFG_W'($urandom_range(0, 7)) << 8));
        cfg_write(REG_QUALITY_OFFSET,  CFG_W'(offs) | (CFG_W'($urandom_range(0, 7)) << 8));
        cfg_write(REG_N_LIMIT,         CFG_W'(nlim));
        cfg_write(REG_MINIMUM_LENGTH,  CFG_W'(minlen));
        cfg_write(REG_PAIRED_MODE,     CFG_W'(paired) | (CFG_W'($urandom) & 11'h7FE));
    endtask

    // ------------------------------------------------------------------
    // Stimulus content
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] good_quality();
        int floor_q;
        int hi;
        floor_q = int'(cur_offset) + int'(cur_threshold);
        if (floor_q > 255)
            return CHAR_W'($urandom);         // no quality can pass
        hi = (floor_q + 40 > 255) ? 255 : floor_q + 40;
        return CHAR_W'($urandom_range(floor_q, hi));
    endfunction

    function automatic logic [CHAR_W-1:0] low_quality();
        int floor_q;
        int hi;
        int lo;
        floor_q = int'(cur_offset) + int'(cur_threshold);
        if (floor_q == 0)
            return CHAR_W'($urandom);         // every quality passes
        hi = (floor_q > 256) ? 255 : floor_q - 1;
        lo = (hi > 30) ? hi - 30 : 0;
        if ($urandom_range(0, 7) == 0)
            lo = 0;
        return CHAR_W'($urandom_range(lo, hi));
    endfunction

    // Well-formed: low-quality ends, N runs at the ends, sparse inner Ns.
    // Noisy: raw bytes and random mate bits. The mate on the final base decides.
    task automatic send_read(input int len, input logic mate, input bit noisy);
        int                lead_low;
        int                tail_low;
        int                lead_n;
        int                tail_n;
        int                i;
        logic              low;
        logic [CHAR_W-1:0] b;
        logic [CHAR_W-1:0] q;
        logic              m;
        lead_low = $urandom_range(0, 3);
        tail_low = $urandom_range(0, 3);
        lead_n   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2);
        tail_n   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2);
        for (i = 0; i < len; i++)
        begin
            if (noisy)
            begin
                b = CHAR_W'($urandom);
                q = CHAR_W'($urandom);
                m = 1'($urandom_range(0, 1));
            end
            else
            begin
                low = (i < lead_low) || (i >= len - tail_low) || ($urandom_range(0, 9) == 0);
                q   = low ? low_quality() : good_quality();
                if (i < lead_n || i >= len - tail_n || $urandom_range(0, 9) == 0)
                    b = $urandom_range(0, 1) ? CHAR_N_UPPER : CHAR_N_LOWER;
                else
                    b = NUCLEOTIDES[8*$urandom_range(0, 3) +: 8];
                m = ($urandom_range(0, 19) == 0) ? ~mate : mate;
                if (i == len - 1)
                    m = mate;
            end
            send_base(b, q, m, i == len - 1);
        end
    endtask

    function automatic int pick_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(41, 120);
        return $urandom_range(1, 40);
    endfunction

    // one single read, or in paired mode a pair with the odd orphan or repeat
    task automatic send_random_record();
        int  kind;
        bit  noisy;
        noisy = ($urandom_range(0, 9) == 0);
        if (!cur_paired)
        begin
            send_read(pick_length(), 1'($urandom_range(0, 1)), noisy);
            return;
        end
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            send_read(pick_length(), 1'b1, noisy);
        end
        else if (kind == 1)
        begin
            send_read(pick_length(), 1'b0, noisy);
            send_read(pick_length(), 1'b0, 1'b0);
            send_read(pick_length(), 1'b1, 1'b0);
        end
        else
        begin
            send_read(pick_length(), 1'b0, noisy);
            send_read(pick_length(), 1'b1, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: threshold 0, offset 33, minimum length 23. A quality
    // just below the offset gives a negative score and counts as low.
    task automatic test_reset_defaults();
        send_base("A", 8'h20, 1'b0, 1'b0);
        send_base("C", "I",   1'b1, 1'b0);
        send_base("G", 8'h20, 1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_single_special_cases();
        // a write to an unused index must leave every register alone
        cfg_write(REG_UNUSED, 11'h7FF);
        set_config(20, 33, 1, 2, 0);
        // no good-quality base at all
        send_base("A", 8'h00, 1'b0, 1'b0);
        send_base("C", 8'h20, 1'b0, 1'b1);
        // only Ns between the first and last good base
        send_base("N", "I",   1'b0, 1'b0);
        send_base("n", "I",   1'b1, 1'b0);
        send_base("N", 8'h20, 1'b0, 1'b1);
        // qualities above 127 are plain unsigned; one inner N at the limit
        send_base("T", 8'hFF, 1'b0, 1'b0);
        send_base("A", 8'h80, 1'b0, 1'b0);
        send_base("N", 8'h90, 1'b1, 1'b0);
        send_base("C", 8'hC8, 1'b0, 1'b1);
        // extreme base bytes; length 2 does not exceed the minimum
        send_base(8'h00, 8'hFF, 1'b1, 1'b0);
        send_base(8'hFF, 8'h7F, 1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_paired_rules();
        cfg_write(REG_PAIRED_MODE, 11'd1);
        // second mate with nothing held
        send_base("A", "I", 1'b1, 1'b1);
        // two first mates in a row: the later one is kept
        send_base("N", "I", 1'b0, 1'b0);
        send_base("G", "I", 1'b0, 1'b1);
        send_base("A", "I", 1'b0, 1'b0);
        send_base("C", "I", 1'b0, 1'b0);
        send_base("G", "I", 1'b0, 1'b1);
        // mate flips inside the read; the final base makes it a second mate
        send_base("T", "I", 1'b0, 1'b0);
        send_base("T", "I", 1'b1, 1'b0);
        send_base("A", "I", 1'b1, 1'b1);
        // left open: this read carries on under the next settings
        send_base("C", "I", 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_phases();
        int phase;
        int stop_at;
        int offs;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drain();
            case (phase)
                0: set_config(0, 0, 0, 0, 0);
                1: set_config(255, 255, 1024, 1024, 1);
                2: set_config(0, 33, 1024, 0, 1);
                3: set_config(255, 0, 0, 1024, 0);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       offs = 33;
                        1:       offs = 64;
                        default: offs = $urandom_range(0, 255);
                    endcase
                    set_config(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 60),
                               offs,
                               ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(0, 4),
                               $urandom_range(0, 30),
                               $urandom_range(0, 1));
                end
            endcase
            // some phases run without idling on one side or the other
            src_idle_on  = (phase % 4 != 3);
            sink_idle_on = (phase % 3 != 2);
            stop_at = bases_sent + PHASE_BASES;
            while (bases_sent < stop_at)
                send_random_record();
        end
        wait_drain();
    endtask

    // a read past the length limit; bases beyond it are dropped
    task automatic test_long_reads();
        int len;
        int i;
        logic [CHAR_W-1:0] b;
        set_config(0, 0, 1024, 1000, 0);
        len = MAX_READ_LEN + 6;
        for (i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 15) == 0) ? CHAR_N_UPPER : CHAR_W'($urandom);
            send_base(b, CHAR_W'($urandom), 1'($urandom_range(0, 1)), i == len - 1);
        end
        wait_drain();
    endtask

    // sink holds off while short reads keep coming, so the input backs up;
    // then the sender waits for every report before going on
    task automatic test_backpressure();
        int i;
        set_config(0, 33, 4, 0, 0);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        @(posedge clk);
        hold_cycles = HOLD_OFF;
        @(negedge clk);
        for (i = 0; i < 40; i++)
            send_read($urandom_range(1, 2), 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_steady_tail();
        int stop_at;
        set_config($urandom_range(0, 40), 33, $urandom_range(0, 3), $urandom_range(0, 20),
                   $urandom_range(0, 1));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stop_at = bases_sent + TAIL_BASES;
        while (bases_sent < stop_at)
            send_random_record();
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = REG_SCORE_THRESHOLD;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        cur_threshold = RST_SCORE_THRESHOLD;
        cur_offset    = RST_QUALITY_OFFSET;
        cur_n_limit   = RST_N_LIMIT;
        cur_min_len   = RST_MINIMUM_LENGTH;
        cur_paired    = 1'b0;
        held_first    = '0;
        held_valid    = 1'b0;
        trim_clear();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_single_special_cases();
        test_paired_rules();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_random_phases();
        src_idle_on  = 1'b1;
        test_long_reads();
        test_backpressure();
        test_steady_tail();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule

/* sim.f */
src/rqnt_pkg.sv
src/rqnt_read_tracker.sv
src/read_quality_and_n_trimmer.sv
bench/testbench.sv
